[hdl/qfts_pkg.sv]
// Shared constants and types for the two-stack queue.
package qfts_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

[hdl/qfts_ram.sv]
// Simple dual-port stack memory with one write port and a registered read port.
module qfts_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/queue_from_two_stacks_unit.sv]
// Top level of the first-in first-out queue built from an input and an output stack.
//
// The input channel carries one word per command: i_operation selects push or pop,
// i_push_value is the word to enqueue. A command is taken when i_in_valid is high
// and o_in_stall is low. Each command yields exactly one result word on the output
// channel (o_pop_value, o_status), taken when o_out_valid is high and i_out_stall
// is low. A push to a full input stack with an empty output stack first moves the
// whole input stack over; any other push to a full input stack returns status full.
// A pop on an empty output stack moves the input stack over first; a pop on an
// empty queue returns status empty and a zero word.
// A command that moves the input stack moves one word per cycle through the stack
// memories. One command is worked on at a time; the next is taken once the current
// one has left for the output register. When the receiver stalls, the result waits
// in the output register and a finished following result waits inside until it is
// free. Synchronous reset empties both stacks and the output register; the memory
// contents are left as they were and are never read below an empty count.
module queue_from_two_stacks_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic signed [31:0]               i_push_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [qfts_pkg::OUT_WIDTH-1:0] o_pop_value,
    output logic [1:0]                       o_status
);

    import qfts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_POP,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_in_cnt, n_in_cnt;
    logic [CNT_W-1:0]      r_out_cnt, n_out_cnt;
    t_op                   r_op, n_op;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [OUT_WIDTH-1:0]  r_res_value, n_res_value;
    t_status               r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_WIDTH-1:0]  r_pop_value, n_pop_value;
    t_status               r_status, n_status;

    logic                  in_we, in_re, out_we, out_re;
    logic [ADDR_W-1:0]     in_waddr, in_raddr, out_waddr, out_raddr;
    logic [DATA_WIDTH-1:0] in_wdata, in_rdata, out_rdata;
    logic [CNT_W-1:0]      in_dec, out_dec;
    logic [DATA_WIDTH-1:0] push_word;

    assign in_dec    = r_in_cnt - CNT_W'(1);
    assign out_dec   = r_out_cnt - CNT_W'(1);
    assign push_word = DATA_WIDTH'(i_push_value);

    qfts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH),
        .ADDR_W(ADDR_W)
    ) u_in_ram (
        .i_clk    (i_clk),
        .i_wr_en  (in_we),
        .i_wr_addr(in_waddr),
        .i_wr_data(in_wdata),
        .i_rd_en  (in_re),
        .i_rd_addr(in_raddr),
        .o_rd_data(in_rdata)
    );

    qfts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH),
        .ADDR_W(ADDR_W)
    ) u_out_ram (
        .i_clk    (i_clk),
        .i_wr_en  (out_we),
        .i_wr_addr(out_waddr),
        .i_wr_data(in_rdata),
        .i_rd_en  (out_re),
        .i_rd_addr(out_raddr),
        .o_rd_data(out_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_in_cnt     = r_in_cnt;
        n_out_cnt    = r_out_cnt;
        n_op         = r_op;
        n_value      = r_value;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_pop_value  = r_pop_value;
        n_status     = r_status;
        in_we        = 1'b0;
        in_re        = 1'b0;
        out_we       = 1'b0;
        out_re       = 1'b0;
        in_waddr     = r_in_cnt[ADDR_W-1:0];
        in_wdata     = push_word;
        in_raddr     = in_dec[ADDR_W-1:0];
        out_waddr    = r_out_cnt[ADDR_W-1:0];
        out_raddr    = out_dec[ADDR_W-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = t_op'(i_operation);
                    n_value      = push_word;
                    n_res_value  = '0;
                    n_res_status = ST_OK;
                    if (t_op'(i_operation) == OP_PUSH) begin
                        if (r_in_cnt < CNT_W'(STACK_DEPTH)) begin
                            in_we    = 1'b1;
                            n_in_cnt = r_in_cnt + CNT_W'(1);
                            n_state  = S_DONE;
                        end else if (r_out_cnt == '0) begin
                            in_re    = 1'b1;
                            n_in_cnt = in_dec;
                            n_state  = S_XFER;
                        end else begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end
                    end else begin
                        if (r_out_cnt != '0) begin
                            out_re    = 1'b1;
                            n_out_cnt = out_dec;
                            n_state   = S_POP;
                        end else if (r_in_cnt != '0) begin
                            in_re    = 1'b1;
                            n_in_cnt = in_dec;
                            n_state  = S_XFER;
                        end else begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_XFER: begin
                if (r_in_cnt != '0) begin
                    out_we    = 1'b1;
                    n_out_cnt = r_out_cnt + CNT_W'(1);
                    in_re     = 1'b1;
                    n_in_cnt  = in_dec;
                end else begin
                    // The last moved word is the oldest one, so a pop takes it directly.
                    if (r_op == OP_PUSH) begin
                        out_we    = 1'b1;
                        n_out_cnt = r_out_cnt + CNT_W'(1);
                        in_we     = 1'b1;
                        in_waddr  = '0;
                        in_wdata  = r_value;
                        n_in_cnt  = CNT_W'(1);
                    end else begin
                        n_res_value = OUT_WIDTH'(in_rdata);
                    end
                    n_state = S_DONE;
                end
            end
            S_POP: begin
                n_res_value = OUT_WIDTH'(out_rdata);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_pop_value = r_res_value;
                    n_status    = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_in_cnt     <= n_in_cnt;
            r_out_cnt    <= n_out_cnt;
            r_out_valid  <= n_out_valid;
            r_op         <= n_op;
            r_value      <= n_value;
            r_res_value  <= n_res_value;
            r_res_status <= n_res_status;
            r_pop_value  <= n_pop_value;
            r_status     <= n_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

endmodule
